// File: rtl/dftpsd_pkg.sv
// Shared types, constants and CORDIC arctangent function for the power-spectrum pixel block.
package dftpsd_pkg;

    typedef struct packed {
        logic       command;
        logic [9:0] position;
        logic [7:0] in_phase;
        logic [7:0] quadrature;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic [9:0] pixel_number;
    } t_out_item;

    typedef enum logic [1:0] {
        CFG_PIXEL_COUNT = 2'd0,
        CFG_DB_OFFSET   = 2'd1,
        CFG_DB_RANGE    = 2'd2
    } t_cfg_index;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIN,
        ST_ROM,
        ST_MAC,
        ST_ROUND,
        ST_POWER,
        ST_NORM,
        ST_LOG,
        ST_DB,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam int          DB_STEP     = 197283;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        begin
            case (i)
                5'd0:  t = 32'h20000000;
                5'd1:  t = 32'h12E4051D;
                5'd2:  t = 32'h09FB385B;
                5'd3:  t = 32'h051111D4;
                5'd4:  t = 32'h028B0D43;
                5'd5:  t = 32'h0145D7E1;
                5'd6:  t = 32'h00A2F61E;
                5'd7:  t = 32'h00517C55;
                5'd8:  t = 32'h0028BE53;
                5'd9:  t = 32'h00145F2E;
                5'd10: t = 32'h000A2F98;
                5'd11: t = 32'h000517CC;
                5'd12: t = 32'h00028BE6;
                5'd13: t = 32'h000145F3;
                5'd14: t = 32'h0000A2F9;
                5'd15: t = 32'h0000517C;
                5'd16: t = 32'h000028BE;
                5'd17: t = 32'h0000145F;
                5'd18: t = 32'h00000A2F;
                5'd19: t = 32'h00000517;
                5'd20: t = 32'h0000028B;
                5'd21: t = 32'h00000145;
                5'd22: t = 32'h000000A2;
                5'd23: t = 32'h00000051;
                5'd24: t = 32'h00000028;
                5'd25: t = 32'h00000014;
                5'd26: t = 32'h0000000A;
                5'd27: t = 32'h00000005;
                5'd28: t = 32'h00000002;
                5'd29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: rtl/dftpsd_twiddle_rom.sv
// Twiddle table built by an iterative CORDIC after reset, then read with registered data.
module dftpsd_twiddle_rom #(
    parameter int POINTS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [$clog2(POINTS)-1:0] i_addr,
    output logic signed [15:0]        o_cos,
    output logic signed [15:0]        o_sin,
    output logic                      o_ready
);
    import dftpsd_pkg::*;

    localparam int AW = $clog2(POINTS);

    logic [31:0] r_mem [POINTS];
    logic [AW:0] r_m;
    logic [4:0]  r_i;
    logic        r_busy;
    logic        r_ready;
    logic        r_neg;
    logic signed [33:0] r_x, r_y, r_z;
    logic [31:0] r_rd;

    logic [31:0]        a32;
    logic signed [33:0] z0, zs;
    logic               neg0;
    logic signed [33:0] dx, dy;
    logic signed [33:0] xf, yf;
    logic signed [15:0] cq, sq;

    function automatic logic signed [15:0] q15(input logic signed [33:0] v);
        logic signed [33:0] t;
        begin
            t = (v + 34'sd16384) >>> 15;
            if (t > 34'sd32767) return 16'sh7fff;
            if (t < -34'sd32768) return 16'sh8000;
            return t[15:0];
        end
    endfunction

    always_comb begin
        a32  = {r_m[AW-1:0], {(32-AW){1'b0}}};
        zs   = {{2{a32[31]}}, a32};
        neg0 = 1'b0;
        z0   = zs;
        if (zs > 34'sd1073741824) begin
            z0 = zs - 34'sd2147483648;
            neg0 = 1'b1;
        end else if (zs < -34'sd1073741824) begin
            z0 = zs + 34'sd2147483648;
            neg0 = 1'b1;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        xf = r_neg ? -r_x : r_x;
        yf = r_neg ? -r_y : r_y;
        cq = q15(xf);
        sq = q15(yf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m     <= '0;
            r_i     <= '0;
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
        end else if (!r_ready) begin
            if (!r_busy) begin
                r_x    <= {2'b00, CORDIC_GAIN};
                r_y    <= '0;
                r_z    <= z0;
                r_neg  <= neg0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_i != 5'd30) begin
                if (!r_z[33]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - $signed({2'b00, atan_turn(r_i)});
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + $signed({2'b00, atan_turn(r_i)});
                end
                r_i <= r_i + 5'd1;
            end else begin
                r_busy <= 1'b0;
                r_m    <= r_m + 1'b1;
                if (r_m == (AW+1)'(POINTS - 1)) begin
                    r_ready <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ready && r_busy && r_i == 5'd30) begin
            r_mem[r_m[AW-1:0]] <= {cq, sq};
        end
        r_rd <= r_mem[i_addr];
    end

    assign o_cos   = r_rd[31:16];
    assign o_sin   = r_rd[15:0];
    assign o_ready = r_ready;

endmodule

// File: rtl/dftpsd_sample_ram.sv
// Sample store: one write port and one registered read port.
module dftpsd_sample_ram #(
    parameter int POINTS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(POINTS)-1:0] i_waddr,
    input  logic [15:0]               i_wdata,
    input  logic [$clog2(POINTS)-1:0] i_raddr,
    output logic [15:0]               o_rdata
);
    logic [15:0] r_mem [POINTS];
    logic [15:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;
endmodule

// File: rtl/dft_power_spectrum_db_pixels_core.sv
// Top level: sequencer around a shared MAC, log2 and divide steps for one pixel per compute command.
//
//  channel | signals                          | handshake
//  in      | i_in_valid o_in_ready i_in_item  | valid/ready
//  out     | o_out_valid i_out_ready o_out_item| valid/ready
//  cfg     | i_cfg_we i_cfg_index i_cfg_data  | write enable
//
// Store item: written to the sample RAM while the core stays idle. Compute item: the result
// comes from the AW+10-step bin divide, one complex MAC per sample, the log2 steps and
// the 9-step scale divide.
// After reset a twiddle build runs; input is not taken until it is done.
// A finished result holds until taken; the next item waits for it.
module dft_power_spectrum_db_pixels_core #(
    parameter int POINTS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  dftpsd_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output dftpsd_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [10:0]           i_cfg_data
);
    import dftpsd_pkg::*;

    localparam int AW = $clog2(POINTS);

    logic [10:0]       r_pc;
    logic signed [8:0] r_off;
    logic [7:0]        r_rng;

    t_state r_state, n_state;
    logic [9:0]  r_pos;
    logic [AW:0] r_j;
    logic [AW-1:0] r_idx, r_k;
    logic signed [47:0] r_re, r_im;
    logic signed [31:0] r_rr, r_ii;
    logic [63:0] r_pw;
    logic [5:0]  r_e;
    logic [31:0] r_mt;
    logic [7:0]  r_frac;
    logic [3:0]  r_cnt;
    logic signed [47:0] r_num;
    logic [8:0]  r_q;
    logic [7:0]  r_val;
    logic        r_sq;
    logic [4:0]  r_dcnt;
    logic [31:0] r_bin;

    logic               rom_ready;
    logic signed [15:0] tw_c, tw_s;
    logic [15:0]        smp;
    logic               in_acc;

    dftpsd_twiddle_rom #(.POINTS(POINTS)) u_rom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_addr(r_idx),
        .o_cos(tw_c), .o_sin(tw_s), .o_ready(rom_ready)
    );

    dftpsd_sample_ram #(.POINTS(POINTS)) u_ram (
        .i_clk(i_clk),
        .i_we(in_acc && i_in_item.command == CMD_STORE),
        .i_waddr(AW'(i_in_item.position)),
        .i_wdata({i_in_item.quadrature, i_in_item.in_phase}),
        .i_raddr(r_j[AW-1:0]),
        .o_rdata(smp)
    );

    assign o_in_ready  = rom_ready && r_state == ST_IDLE;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_state == ST_OUT;
    assign o_out_item  = '{pixel_value: r_val, pixel_number: r_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= 11'd1024;
            r_off <= -9'sd100;
            r_rng <= 8'd70;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_COUNT: r_pc  <= i_cfg_data;
                CFG_DB_OFFSET:   r_off <= i_cfg_data[8:0];
                CFG_DB_RANGE:    r_rng <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // shared datapath signals
    logic [12:0]        pc_eff;
    logic signed [9:0]  si, sq;
    logic signed [26:0] pa, pb, pc2, pd;
    logic signed [31:0] sqsel;
    logic signed [63:0] sq64;
    logic [63:0]        sqr;
    logic [63:0]        mm;
    logic [5:0]         lz;
    logic signed [31:0] l8;
    logic signed [47:0] dbq;
    logic [31:0]        den;
    logic signed [47:0] trial;

    always_comb begin
        pc_eff = (r_pc == 11'd0 || 13'(r_pc) > 13'(POINTS)) ? 13'(POINTS) : 13'(r_pc);
        si  = $signed({1'b0, smp[7:0], 1'b0}) - 10'sd255;
        sq  = $signed({1'b0, smp[15:8], 1'b0}) - 10'sd255;
        pa  = si * tw_c;
        pb  = sq * tw_s;
        pc2 = sq * tw_c;
        pd  = si * tw_s;
        sqsel = r_sq ? r_ii : r_rr;
        sq64  = 64'(sqsel) * 64'(sqsel);
        sqr   = $unsigned(sq64);
        mm  = 64'(r_mt) * 64'(r_mt);
        lz  = '0;
        for (int b = 0; b < 64; b++) begin
            if (r_pw[b]) lz = 6'(b);
        end
        l8  = $signed({18'd0, r_e, r_frac}) - 32'sd5120;
        dbq = (r_pw == 64'd0) ? -48'sd1677721600 : 48'(l8) * 48'(DB_STEP);
        den = {(r_rng == 8'd0) ? 8'd1 : r_rng, 24'd0};
        trial = r_num - ($signed({16'd0, den}) <<< r_dcnt[3:0]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc && i_in_item.command == CMD_COMPUTE) n_state = ST_BIN;
            ST_BIN:   if (r_dcnt == 5'd0) n_state = ST_ROM;
            ST_ROM:   n_state = ST_MAC;
            ST_MAC:   if (r_j == (AW+1)'(POINTS)) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_POWER;
            ST_POWER: if (r_sq) n_state = ST_NORM;
            ST_NORM:  n_state = ST_LOG;
            ST_LOG:   if (r_cnt == 4'd8) n_state = ST_DB;
            ST_DB:    n_state = ST_DIV;
            ST_DIV:   if (r_dcnt == 5'd0) n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pos <= i_in_item.position;
                r_bin <= 32'(i_in_item.position) << AW;
                r_k   <= '0;
                r_cnt <= 4'd0;
                r_dcnt <= 5'(AW + 9);
            end
            ST_BIN: begin
                // restoring divide of pos*POINTS by pixel count, one quotient bit a cycle
                if ((r_bin >> r_dcnt) >= 32'(pc_eff)) begin
                    r_bin <= r_bin - (32'(pc_eff) << r_dcnt);
                    r_k   <= r_k | AW'(1 << r_dcnt);
                end
                if (r_dcnt == 5'd0) r_cnt <= 4'd0;
                else begin
                    r_dcnt <= r_dcnt - 5'd1;
                    r_cnt  <= 4'd1;
                end
                r_j   <= '0;
                r_idx <= '0;
                r_re  <= '0;
                r_im  <= '0;
            end
            ST_ROM: begin
                r_j   <= r_j + 1'b1;
                r_idx <= r_idx + r_k;
            end
            ST_MAC: begin
                r_re  <= r_re + 48'(pa) + 48'(pb);
                r_im  <= r_im + 48'(pc2) - 48'(pd);
                r_j   <= r_j + 1'b1;
                r_idx <= r_idx + r_k;
                r_sq  <= 1'b0;
            end
            ST_ROUND: begin
                r_rr <= 32'((r_re + 48'sd32) >>> 6);
                r_ii <= 32'((r_im + 48'sd32) >>> 6);
                r_pw <= '0;
            end
            ST_POWER: begin
                r_pw <= r_pw + sqr;
                r_sq <= 1'b1;
            end
            ST_NORM: begin
                r_e    <= lz;
                r_mt   <= (lz >= 6'd30) ? 32'(r_pw >> (lz - 6'd30))
                                        : 32'(r_pw << (6'd30 - lz));
                r_frac <= '0;
                r_cnt  <= 4'd0;
            end
            ST_LOG: begin
                if (r_cnt != 4'd8) begin
                    if (mm[61]) begin
                        r_mt   <= 32'(mm >> 31);
                        r_frac <= {r_frac[6:0], 1'b1};
                    end else begin
                        r_mt   <= 32'(mm >> 30);
                        r_frac <= {r_frac[6:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
            end
            ST_DB: begin
                r_num  <= ((dbq - (48'(r_off) <<< 24)) <<< 8) - (dbq - (48'(r_off) <<< 24));
                r_dcnt <= 5'd8;
                r_q    <= '0;
            end
            ST_DIV: begin
                if (r_num < 0) begin
                    r_val <= 8'd0;
                end else begin
                    if (trial >= 0) begin
                        r_num <= trial;
                        r_q   <= r_q | 9'(1 << r_dcnt);
                    end
                    r_val <= (r_q | ((trial >= 0) ? 9'(1 << r_dcnt) : 9'd0)) > 9'd255
                             ? 8'd255
                             : 8'(r_q | ((trial >= 0) ? 9'(1 << r_dcnt) : 9'd0));
                end
                if (r_dcnt != 5'd0) r_dcnt <= r_dcnt - 5'd1;
            end
            default: ;
        endcase
    end

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("input taken while result pending");
    a_idle_until_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state != ST_IDLE && !rom_ready))
        else $error("busy before twiddle table ready");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");
    a_store_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.command == CMD_STORE |=> !o_out_valid)
        else $error("store produced result");
    a_compute_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.command == CMD_COMPUTE |=> r_state == ST_BIN)
        else $error("compute not started");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the power-spectrum pixel core: directed table, then random items.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dftpsd_pkg::*;

    localparam int          NPTS       = 1024;
    localparam logic [1:0]  CFG_UNUSED = 2'd3;
    localparam longint      DB_UNIT    = 64'sd16777216;

    localparam logic [31:0] ANGLE_STEP [30] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    typedef struct {
        bit         is_reg;
        logic [1:0] reg_index;
        logic [10:0] reg_data;
        t_in_item   item;
        bit         typed;
        logic [7:0] want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    logic [15:0] sample_mem [NPTS];
    int          cos_tab [NPTS];
    int          sin_tab [NPTS];
    int unsigned pix_count_reg = 1024;
    int          db_offset_reg = -100;
    int unsigned db_range_reg = 70;
    t_out_item   pixel_queue [$];
    t_row        dir_rows [$];
    bit          steady = 1'b0;
    bit          failed = 1'b0;

    always #5 i_clk = ~i_clk;

    dft_power_spectrum_db_pixels_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    function automatic int q15_round(longint q30);
        longint t;
        t = (q30 + 16384) >>> 15;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return int'(t);
    endfunction

    function automatic void build_twiddles();
        longint x, y, z, dx, dy;
        bit     flip;
        for (int m = 0; m < NPTS; m++) begin
            z = longint'(m) << 22;
            if (z >= 64'sh80000000) z = z - 64'sh100000000;
            flip = 1'b0;
            x = 652032874;
            y = 0;
            if (z > 64'sd1073741824) begin
                z = z - 64'sd2147483648;
                flip = 1'b1;
            end else if (z < -64'sd1073741824) begin
                z = z + 64'sd2147483648;
                flip = 1'b1;
            end
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'(ANGLE_STEP[i]);
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'(ANGLE_STEP[i]);
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            cos_tab[m] = q15_round(x);
            sin_tab[m] = q15_round(y);
        end
    endfunction

    function automatic longint log2_q8(longint unsigned v);
        int              e;
        longint unsigned m;
        longint          frac;
        e = 63;
        frac = 0;
        while (v[e] == 1'b0) e--;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int i = 0; i < 8; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h80000000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(e) * 256 + frac;
    endfunction

    function automatic t_out_item predict_pixel(logic [9:0] pixel);
        int unsigned     pc, bin, tw;
        longint          re, im, si, sq, rr, ii, dbq, num, den, val;
        longint unsigned pw;
        t_out_item       r;
        pc = pix_count_reg;
        if (pc == 0 || pc > NPTS) pc = NPTS;
        bin = ((pixel * NPTS) / pc) % NPTS;
        re = 0;
        im = 0;
        tw = 0;
        for (int j = 0; j < NPTS; j++) begin
            si = 2 * longint'(sample_mem[j][7:0]) - 255;
            sq = 2 * longint'(sample_mem[j][15:8]) - 255;
            re += si * cos_tab[tw] + sq * sin_tab[tw];
            im += sq * cos_tab[tw] - si * sin_tab[tw];
            tw = (tw + bin) % NPTS;
        end
        rr = (re + 32) >>> 6;
        ii = (im + 32) >>> 6;
        pw = longint'(rr * rr) + longint'(ii * ii);
        if (pw == 0) dbq = -100 * DB_UNIT;
        else dbq = (log2_q8(pw) - 20 * 256) * 197283;
        num = (dbq - longint'(db_offset_reg) * DB_UNIT) * 255;
        den = longint'(db_range_reg == 0 ? 1 : db_range_reg) * DB_UNIT;
        if (num < 0) val = 0;
        else begin
            val = num / den;
            if (val > 255) val = 255;
        end
        r.pixel_value = val[7:0];
        r.pixel_number = pixel;
        return r;
    endfunction

    task automatic send_item(t_in_item it);
        while (!steady && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.command == CMD_STORE) sample_mem[it.position] = {it.quadrature, it.in_phase};
        else pixel_queue.push_back(predict_pixel(it.position));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PIXEL_COUNT: pix_count_reg = data;
            CFG_DB_OFFSET:   db_offset_reg = $signed(data[8:0]);
            CFG_DB_RANGE:    db_range_reg = data[7:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel item %p", o_out_item);
                    failed = 1'b1;
                end else begin
                    want = pixel_queue.pop_front();
                    if (o_out_item.pixel_value !== want.pixel_value) begin
                        $error("pixel_value: expected %0d, actual %0d",
                               want.pixel_value, o_out_item.pixel_value);
                        failed = 1'b1;
                    end
                    if (o_out_item.pixel_number !== want.pixel_number) begin
                        $error("pixel_number: expected %0d, actual %0d",
                               want.pixel_number, o_out_item.pixel_number);
                        failed = 1'b1;
                    end
                end
            end
            i_out_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    initial begin
        #40ms;
        $display("dft_power_spectrum_db_pixels_core regression: fail");
        $finish;
    end

    initial begin
        t_in_item it;
        t_row     row;
        int       pick;
        build_twiddles();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every slot: alternating +1/-1 samples cancel at bin zero
        steady = 1'b1;
        for (int j = 0; j < NPTS; j++) begin
            it = '{CMD_STORE, 10'(j), (j % 2) ? 8'd128 : 8'd127, (j % 2) ? 8'd128 : 8'd127};
            send_item(it);
        end
        steady = 1'b0;

        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd0, 8'd0, 8'd0}, 1, 8'd0});
        dir_rows.push_back('{1, CFG_DB_OFFSET, 11'h138, '0, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_RANGE, 11'd0, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd0, 8'hFF, 8'hFF}, 1, 8'd255});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd512, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_PIXEL_COUNT, 11'd1, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd1023, 8'd0, 8'd0}, 1, 8'd255});
        dir_rows.push_back('{1, CFG_PIXEL_COUNT, 11'd0, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd512, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_PIXEL_COUNT, 11'h7FF, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd1, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_STORE, 10'd0, 8'hFF, 8'h00}, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_STORE, 10'd1023, 8'h00, 8'hFF}, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_STORE, 10'd5, 8'hFF, 8'hFF}, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_STORE, 10'd6, 8'h00, 8'h00}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_OFFSET, 11'h0FF, '0, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_RANGE, 11'd255, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd0, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_OFFSET, 11'h100, '0, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_RANGE, 11'd1, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd300, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_UNUSED, 11'h7FF, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd7, 8'd0, 8'd0}, 0, 8'd0});
        dir_rows.push_back('{1, CFG_PIXEL_COUNT, 11'd1024, '0, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_OFFSET, 11'h19C, '0, 0, 8'd0});
        dir_rows.push_back('{1, CFG_DB_RANGE, 11'd70, '0, 0, 8'd0});
        dir_rows.push_back('{0, 2'd0, 11'd0, '{CMD_COMPUTE, 10'd100, 8'd0, 8'd0}, 0, 8'd0});

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            if (row.is_reg) begin
                write_reg(row.reg_index, row.reg_data);
            end else begin
                send_item(row.item);
                if (row.typed) pixel_queue[$].pixel_value = row.want;
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            pick = $urandom_range(5);
            write_reg(CFG_PIXEL_COUNT, pick == 0 ? 11'd1 : pick == 1 ? 11'd1024 :
                      pick == 2 ? 11'd0 : pick == 3 ? 11'h7FF : 11'($urandom));
            write_reg(CFG_DB_OFFSET, phase == 0 ? 11'h138 : phase == 1 ? 11'h0C8 :
                      11'($urandom_range(511)));
            write_reg(CFG_DB_RANGE, phase == 0 ? 11'd0 : phase == 1 ? 11'd255 :
                      11'($urandom_range(255)));
            steady = (phase == 2);
            for (int n = 0; n < 116; n++) begin
                it = t_in_item'(27'($urandom));
                it.command = ($urandom_range(99) < 40) ? CMD_COMPUTE : CMD_STORE;
                send_item(it);
            end
            steady = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (!failed)
            $display("dft_power_spectrum_db_pixels_core regression: pass");
        else
            $display("dft_power_spectrum_db_pixels_core regression: fail");
        $finish;
    end
endmodule

// File: files.f
rtl/dftpsd_pkg.sv
rtl/dftpsd_twiddle_rom.sv
rtl/dftpsd_sample_ram.sv
rtl/dft_power_spectrum_db_pixels_core.sv
bench/testbench.sv
